// File: design/spc_alu_pkg.sv
// ----------------------------------------------------------------------------
// spc_alu_pkg
// Operation codes, status bit positions and the pipeline payload type of the
// sound CPU arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_alu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    OP_ADC  = 5'd0,
    OP_SBC  = 5'd1,
    OP_CMP  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_EOR  = 5'd5,
    OP_ASL  = 5'd6,
    OP_ROL  = 5'd7,
    OP_LSR  = 5'd8,
    OP_ROR  = 5'd9,
    OP_INC  = 5'd10,
    OP_DEC  = 5'd11,
    OP_XCN  = 5'd12,
    OP_ADDW = 5'd13,
    OP_SUBW = 5'd14,
    OP_CMPW = 5'd15,
    OP_INCW = 5'd16,
    OP_DECW = 5'd17,
    OP_MUL  = 5'd18,
    OP_DIV  = 5'd19
  } op_t;

  // status bit positions
  localparam int unsigned FlN = 7;
  localparam int unsigned FlV = 6;
  localparam int unsigned FlH = 3;
  localparam int unsigned FlZ = 1;
  localparam int unsigned FlC = 0;

  // divider layout: dividend bits retired per stage and number of stages
  localparam int unsigned DivBits       = 16;
  localparam int unsigned DivStages     = 4;
  localparam int unsigned BitsPerStage  = DivBits / DivStages;

  // payload carried down the pipeline
  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  fl;
    logic        is_div;
    logic        dcase1;
    logic [7:0]  x;
    logic [15:0] num;
    logic [8:0]  den;
    logic [8:0]  rem;
    logic [7:0]  quo;
  } stage_t;

  // set N and Z from a byte
  function automatic logic [7:0] nz8(input logic [7:0] f, input logic [7:0] r);
    logic [7:0] o;
    o      = f;
    o[FlN] = r[7];
    o[FlZ] = (r == 8'h00);
    return o;
  endfunction

  // set N and Z from a word
  function automatic logic [7:0] nz16(input logic [7:0] f, input logic [15:0] w);
    logic [7:0] o;
    o      = f;
    o[FlN] = w[15];
    o[FlZ] = (w == 16'h0000);
    return o;
  endfunction

endpackage

`default_nettype wire

// File: design/spc700_alu.sv
// ----------------------------------------------------------------------------
// spc700_alu
// Pipelined arithmetic unit of an 8-bit sound CPU: byte, word, multiply and
// divide operations with status update.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  in_*      input      in_valid / in_stall    operation, acc, high_y,
//                                              divisor_x, mem_lo, mem_hi, flags_in
//  out_*     output     out_valid / out_stall  result_lo, result_hi, flags_out
//
//  one transaction enters per cycle while in_stall is low; every operation
//  passes through the setup stage, the divider stages and the output register
//  the depth is set by the divider: four stages of four restoring steps each,
//  after a setup stage, then the output register
//  rst_n (synchronous) clears the stage valid bits only
//  out_stall holds the whole pipeline; in_stall is high while the output
//  register is full and stalled
// ----------------------------------------------------------------------------
`default_nettype none

module spc700_alu (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [4:0] in_operation,
  input  wire logic [7:0] in_acc,
  input  wire logic [7:0] in_high_y,
  input  wire logic [7:0] in_divisor_x,
  input  wire logic [7:0] in_mem_lo,
  input  wire logic [7:0] in_mem_hi,
  input  wire logic [7:0] in_flags_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_result_lo,
  output logic [7:0]      out_result_hi,
  output logic [7:0]      out_flags_out
);

  localparam int unsigned NSt = spc_alu_pkg::DivStages + 1;

  logic                  adv;
  spc_alu_pkg::stage_t   pipe_r [NSt];
  spc_alu_pkg::stage_t   pipe_nxt [NSt];
  logic [NSt-1:0]        vld_r;
  logic                  out_valid_r;
  logic [7:0]            out_lo_r, out_hi_r, out_fl_r;
  logic [7:0]            fin_lo, fin_hi, fin_fl;

  // whole pipeline moves when the output can take or drop its transaction
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // setup stage: all non-divide results and the divider operands
  always_comb begin
    logic [7:0]  a, y, x, ml, mh, f, d;
    logic        cin;
    logic [8:0]  s9;
    logic [4:0]  h5;
    logic [15:0] mw, ya, w16;
    logic [16:0] w17, t17, n17;
    logic [8:0]  cc;
    spc_alu_pkg::stage_t st;
    a   = in_acc;
    y   = in_high_y;
    x   = in_divisor_x;
    ml  = in_mem_lo;
    mh  = in_mem_hi;
    f   = in_flags_in;
    cin = f[spc_alu_pkg::FlC];
    mw  = {mh, ml};
    ya  = {y, a};
    d   = '0;
    s9  = '0;
    h5  = '0;
    w16 = '0;
    w17 = '0;
    t17 = '0;
    n17 = '0;
    cc  = '0;
    st        = '0;
    st.lo     = a;
    st.hi     = y;
    st.fl     = f;
    st.x      = x;
    st.den    = 9'd1;
    unique case (in_operation)
      spc_alu_pkg::OP_ADC, spc_alu_pkg::OP_SBC: begin
        d  = (in_operation == spc_alu_pkg::OP_SBC) ? ~ml : ml;
        s9 = {1'b0, a} + {1'b0, d} + {8'd0, cin};
        h5 = {1'b0, a[3:0]} + {1'b0, d[3:0]} + {4'd0, cin};
        st.fl[spc_alu_pkg::FlH] = h5[4];
        st.fl[spc_alu_pkg::FlV] = ~(a[7] ^ d[7]) & (a[7] ^ s9[7]);
        st.fl[spc_alu_pkg::FlC] = s9[8];
        st.lo = s9[7:0];
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_CMP: begin
        st.fl[spc_alu_pkg::FlC] = (a >= ml);
        st.fl = spc_alu_pkg::nz8(st.fl, a - ml);
      end
      spc_alu_pkg::OP_AND: begin
        st.lo = a & ml;
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_OR: begin
        st.lo = a | ml;
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_EOR: begin
        st.lo = a ^ ml;
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_ASL, spc_alu_pkg::OP_ROL: begin
        st.lo = {a[6:0], (in_operation == spc_alu_pkg::OP_ROL) ? cin : 1'b0};
        st.fl[spc_alu_pkg::FlC] = a[7];
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_LSR, spc_alu_pkg::OP_ROR: begin
        st.lo = {(in_operation == spc_alu_pkg::OP_ROR) ? cin : 1'b0, a[7:1]};
        st.fl[spc_alu_pkg::FlC] = a[0];
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_INC: begin
        st.lo = a + 8'd1;
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_DEC: begin
        st.lo = a - 8'd1;
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_XCN: begin
        st.lo = {a[3:0], a[7:4]};
        st.fl = spc_alu_pkg::nz8(st.fl, st.lo);
      end
      spc_alu_pkg::OP_ADDW, spc_alu_pkg::OP_SUBW: begin
        // negated word of SUBW keeps its 17th bit when the word is zero
        w17 = (in_operation == spc_alu_pkg::OP_SUBW) ?
              ({1'b0, ~mw} + 17'd1) : {1'b0, mw};
        t17 = w17 + {9'd0, a};
        cc  = {1'b0, y} + t17[16:8];
        st.lo = t17[7:0];
        st.hi = cc[7:0];
        st.fl[spc_alu_pkg::FlH] = (cc[3:0] < y[3:0]);
        st.fl[spc_alu_pkg::FlV] = (cc[7] ^ y[7]) & ~(y[7] ^ w17[15]);
        st.fl[spc_alu_pkg::FlC] = cc[8];
        st.fl = spc_alu_pkg::nz16(st.fl, {cc[7:0], t17[7:0]});
      end
      spc_alu_pkg::OP_CMPW: begin
        st.fl[spc_alu_pkg::FlC] = (ya >= mw);
        st.fl = spc_alu_pkg::nz16(st.fl, ya - mw);
      end
      spc_alu_pkg::OP_INCW, spc_alu_pkg::OP_DECW: begin
        w16 = (in_operation == spc_alu_pkg::OP_INCW) ? (mw + 16'd1) : (mw - 16'd1);
        st.lo = w16[7:0];
        st.hi = w16[15:8];
        st.fl = spc_alu_pkg::nz16(st.fl, w16);
      end
      spc_alu_pkg::OP_MUL: begin
        w16 = {8'd0, y} * {8'd0, a};
        st.lo = w16[7:0];
        st.hi = w16[15:8];
        st.fl = spc_alu_pkg::nz16(st.fl, w16);
      end
      spc_alu_pkg::OP_DIV: begin
        // normal divide when Y < 2X, else the wrapped form over 256 - X
        st.is_div = 1'b1;
        st.fl[spc_alu_pkg::FlH] = (y[3:0] >= x[3:0]);
        st.fl[spc_alu_pkg::FlV] = (y >= x);
        st.dcase1 = ({1'b0, y} < {x, 1'b0});
        n17 = {1'b0, ya} - {x, 9'd0};
        st.num = st.dcase1 ? ya : n17[15:0];
        st.den = st.dcase1 ? {1'b0, x} : (9'd256 - {1'b0, x});
      end
      default: begin
      end
    endcase
    pipe_nxt[0] = st;
  end

  // divider stages: restoring steps, one quotient bit each
  for (genvar g = 1; g < NSt; g++) begin : g_div
    always_comb begin
      logic [9:0] rs;
      spc_alu_pkg::stage_t st;
      st = pipe_r[g-1];
      rs = '0;
      for (int k = 0; k < spc_alu_pkg::BitsPerStage; k++) begin
        rs     = {st.rem, st.num[15]};
        st.num = {st.num[14:0], 1'b0};
        if (rs >= {1'b0, st.den}) begin
          rs     = rs - {1'b0, st.den};
          st.quo = {st.quo[6:0], 1'b1};
        end else begin
          st.quo = {st.quo[6:0], 1'b0};
        end
        st.rem = rs[8:0];
      end
      pipe_nxt[g] = st;
    end
  end

  // final selection: divide results; other operations pass through
  always_comb begin
    spc_alu_pkg::stage_t st;
    st     = pipe_r[NSt-1];
    fin_lo = st.lo;
    fin_hi = st.hi;
    fin_fl = st.fl;
    if (st.is_div) begin
      fin_lo = st.dcase1 ? st.quo : ~st.quo;
      fin_hi = st.dcase1 ? st.rem[7:0] : (st.x + st.rem[7:0]);
      fin_fl = spc_alu_pkg::nz8(st.fl, fin_lo);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSt; i++) begin
        pipe_r[i] <= pipe_nxt[i];
      end
      out_lo_r <= fin_lo;
      out_hi_r <= fin_hi;
      out_fl_r <= fin_fl;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[NSt-2:0], in_valid};
      out_valid_r <= vld_r[NSt-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_lo = out_lo_r;
  assign out_result_hi = out_hi_r;
  assign out_flags_out = out_fl_r;

endmodule

`default_nettype wire
